### rtl/core/alu16_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alu16_pkg
// Shared types and constants for the 16-bit ALU with NZVC flags: the operation
// codes and the packed input and result items.
// ----------------------------------------------------------------------------
package alu16_pkg;

    localparam int unsigned DataW = 16;
    localparam int unsigned ModeW = 4;

    // Operation codes carried in the mode field. Code 15 is unused and acts
    // as a no-operation.
    typedef enum logic [ModeW-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_CPW = 4'd2,
        OP_CPB = 4'd3,
        OP_AND = 4'd4,
        OP_OR  = 4'd5,
        OP_XOR = 4'd6,
        OP_LDW = 4'd7,
        OP_LDB = 4'd8,
        OP_NEG = 4'd9,
        OP_ASL = 4'd10,
        OP_ASR = 4'd11,
        OP_NOT = 4'd12,
        OP_ROL = 4'd13,
        OP_ROR = 4'd14
    } t_alu_op;

    localparam logic [DataW-1:0] SignMin = 16'h8000;

    // One input item.
    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [DataW-1:0] operand_a;
        logic [DataW-1:0] operand_b;
        logic             flag_n_in;
        logic             flag_z_in;
        logic             flag_v_in;
        logic             flag_c_in;
    } t_alu_in;

    // One result item.
    typedef struct packed {
        logic [DataW-1:0] result;
        logic             write_back;
        logic             flag_n_out;
        logic             flag_z_out;
        logic             flag_v_out;
        logic             flag_c_out;
    } t_alu_out;

endpackage
`default_nettype wire

### rtl/core/alu16_with_nzvc_flags_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alu16_with_nzvc_flags_top
// 16-bit ALU that returns a result, a write-back enable and new N, Z, V and C
// flags for add, subtract, compares, logic ops, loads, negate, shifts and
// rotates through carry.
// ----------------------------------------------------------------------------
//  Channel  | Ports                 | Handshake
//  ---------+-----------------------+---------------------------------------
//  input    | start, busy, i_item   | item taken when start is high, busy low
//  result   | o_valid, o_item       | item shown for one cycle, o_valid high
//
// Each item passes through two registers, the input register and then the
// result register. Its result is on the ports, with o_valid high, once the
// result register has taken it.
// A new item is accepted in every cycle; busy is always low because the
// single-pass datapath never holds an item back and the receiver cannot stall.
// Synchronous active-low reset clears both valid flags; items in flight are
// dropped.
// ----------------------------------------------------------------------------
module alu16_with_nzvc_flags_top
    import alu16_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_alu_in  i_item,
    output logic          o_valid,
    output t_alu_out      o_item
);

    logic     r_in_valid;
    t_alu_in  r_in;
    logic     r_out_valid;
    t_alu_out r_out;
    t_alu_out n_out;

    logic [DataW:0]   sum_ext;
    logic [DataW:0]   diff_ext;
    logic [DataW-1:0] neg_b;
    logic [DataW-1:0] neg_a;
    logic [7:0]       byte_diff;
    logic [DataW-1:0] res;
    logic             v_add;
    logic             v_sub;

    // The block never stalls the sender.
    assign busy = 1'b0;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        if (start && !busy) begin
            r_in <= i_item;
        end
    end

    // Shared arithmetic terms.
    assign sum_ext   = {1'b0, r_in.operand_a} + {1'b0, r_in.operand_b};
    assign diff_ext  = {1'b0, r_in.operand_a} + {1'b0, ~r_in.operand_b} + 17'd1;
    assign neg_b     = ~r_in.operand_b + 16'd1;
    assign neg_a     = ~r_in.operand_a + 16'd1;
    assign byte_diff = r_in.operand_a[7:0] - r_in.operand_b[7:0];
    assign v_add     = ~(r_in.operand_a[15] ^ r_in.operand_b[15])
                     & (r_in.operand_a[15] ^ sum_ext[15]);
    assign v_sub     = ~(r_in.operand_a[15] ^ neg_b[15])
                     & (r_in.operand_a[15] ^ diff_ext[15]);

    // Operation select and flag generation.
    always_comb begin
        res              = r_in.operand_a;
        n_out.write_back = 1'b1;
        n_out.flag_n_out = r_in.flag_n_in;
        n_out.flag_z_out = r_in.flag_z_in;
        n_out.flag_v_out = r_in.flag_v_in;
        n_out.flag_c_out = r_in.flag_c_in;
        n_out.result     = r_in.operand_a;

        case (t_alu_op'(r_in.mode))
            OP_ADD: begin
                res              = sum_ext[DataW-1:0];
                n_out.flag_v_out = v_add;
                n_out.flag_c_out = sum_ext[DataW];
            end
            OP_SUB, OP_CPW: begin
                res              = diff_ext[DataW-1:0];
                n_out.flag_v_out = v_sub;
                n_out.flag_c_out = diff_ext[DataW];
            end
            OP_AND: res = r_in.operand_a & r_in.operand_b;
            OP_OR:  res = r_in.operand_a | r_in.operand_b;
            OP_XOR: res = r_in.operand_a ^ r_in.operand_b;
            OP_LDW: res = r_in.operand_b;
            OP_LDB: res = {8'h00, r_in.operand_b[7:0]};
            OP_NEG: begin
                res              = neg_a;
                n_out.flag_v_out = (neg_a == SignMin);
                n_out.flag_c_out = (r_in.operand_a == '0);
            end
            OP_ASL: begin
                res              = {r_in.operand_a[14:0], 1'b0};
                n_out.flag_v_out = r_in.operand_a[15] ^ r_in.operand_a[14];
                n_out.flag_c_out = r_in.operand_a[15];
            end
            OP_ASR: begin
                res              = {r_in.operand_a[15], r_in.operand_a[15:1]};
                n_out.flag_v_out = 1'b0;
                n_out.flag_c_out = r_in.operand_a[0];
            end
            OP_NOT: res = ~r_in.operand_a;
            OP_ROL: begin
                res              = {r_in.operand_a[14:0], r_in.flag_c_in};
                n_out.flag_c_out = r_in.operand_a[15];
            end
            OP_ROR: begin
                res              = {r_in.flag_c_in, r_in.operand_a[15:1]};
                n_out.flag_c_out = r_in.operand_a[0];
            end
            default: res = r_in.operand_a;
        endcase

        // N and Z follow the computed value for every defined operation; the
        // special cases below override them.
        n_out.result = res;
        case (t_alu_op'(r_in.mode))
            OP_CPW: begin
                n_out.flag_n_out = res[15] ^ v_sub;
                n_out.flag_z_out = (res == '0);
                n_out.result     = r_in.operand_a;
                n_out.write_back = 1'b0;
            end
            OP_CPB: begin
                n_out.flag_n_out = byte_diff[7];
                n_out.flag_z_out = (byte_diff == 8'h00);
                n_out.flag_v_out = 1'b0;
                n_out.flag_c_out = 1'b0;
                n_out.write_back = 1'b0;
            end
            OP_LDB: begin
                n_out.flag_n_out = 1'b0;
                n_out.flag_z_out = (res == '0);
            end
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_LDW, OP_NEG,
            OP_ASL, OP_ASR, OP_NOT, OP_ROL, OP_ROR: begin
                n_out.flag_n_out = res[15];
                n_out.flag_z_out = (res == '0);
            end
            default: begin
                // Unused code: no write-back, flags pass through.
                n_out.write_back = 1'b0;
            end
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 16-bit ALU with NZVC flags. Operations are driven
// through the start/busy command port, and each accepted item gets a predicted
// result and flag set. Every strobed result is compared field by field with
// the oldest prediction. Directed corner cases come first, then random
// traffic in phases with different amounts of sender idling.
// ----------------------------------------------------------------------------
module tb_top;
    import alu16_pkg::*;

    // Unused operation code, treated as a no-operation by the block.
    localparam logic [ModeW-1:0] ModeNop = 4'd15;
    localparam int unsigned ItemsPerPhase = 440;
    localparam int unsigned ReportLimit = 10;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_alu_in  i_item;
    logic     o_valid;
    t_alu_out o_item;

    // Holds the expected ALU results in order and compares the outputs.
    class alu_flag_scoreboard;
        t_alu_out    pending_results[$];
        int unsigned mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // Works out the result, write-back enable and new flags of one item.
        function t_alu_out compute_alu(t_alu_in it);
            logic [DataW:0]   sum;
            logic [DataW-1:0] a;
            logic [DataW-1:0] b;
            logic [DataW-1:0] r;
            logic [DataW-1:0] neg_b;
            logic [7:0]       byte_diff;
            t_alu_out         o;
            a = it.operand_a;
            b = it.operand_b;
            r = a;
            o.write_back = 1'b1;
            o.flag_n_out = it.flag_n_in;
            o.flag_z_out = it.flag_z_in;
            o.flag_v_out = it.flag_v_in;
            o.flag_c_out = it.flag_c_in;
            case (it.mode)
                OP_ADD: begin
                    sum = {1'b0, a} + {1'b0, b};
                    r = sum[DataW-1:0];
                    o.flag_v_out = ~(a[15] ^ b[15]) & (a[15] ^ r[15]);
                    o.flag_c_out = sum[DataW];
                end
                OP_SUB, OP_CPW: begin
                    sum = {1'b0, a} + {1'b0, ~b} + 17'd1;
                    r = sum[DataW-1:0];
                    // Overflow follows the add rule on the negated operand.
                    neg_b = ~b + 16'd1;
                    o.flag_v_out = ~(a[15] ^ neg_b[15]) & (a[15] ^ r[15]);
                    o.flag_c_out = sum[DataW];
                end
                OP_CPB: begin
                    byte_diff = a[7:0] - b[7:0];
                    o.flag_v_out = 1'b0;
                    o.flag_c_out = 1'b0;
                end
                OP_AND: r = a & b;
                OP_OR:  r = a | b;
                OP_XOR: r = a ^ b;
                OP_LDW: r = b;
                OP_LDB: r = {8'h00, b[7:0]};
                OP_NEG: begin
                    r = ~a + 16'd1;
                    o.flag_v_out = (r == SignMin);
                    o.flag_c_out = (a == '0);
                end
                OP_ASL: begin
                    r = {a[14:0], 1'b0};
                    o.flag_v_out = a[15] ^ r[15];
                    o.flag_c_out = a[15];
                end
                OP_ASR: begin
                    r = {a[15], a[15:1]};
                    o.flag_v_out = 1'b0;
                    o.flag_c_out = a[0];
                end
                OP_NOT: r = ~a;
                OP_ROL: begin
                    r = {a[14:0], it.flag_c_in};
                    o.flag_c_out = a[15];
                end
                OP_ROR: begin
                    r = {it.flag_c_in, a[15:1]};
                    o.flag_c_out = a[0];
                end
                default: o.write_back = 1'b0;
            endcase

            // N and Z follow the word result except where noted below.
            if (it.mode != ModeNop) begin
                o.flag_n_out = r[15];
                o.flag_z_out = (r == '0);
            end
            if (it.mode == OP_LDB) begin
                o.flag_n_out = 1'b0;
            end
            if (it.mode == OP_CPB) begin
                o.flag_n_out = byte_diff[7];
                o.flag_z_out = (byte_diff == 8'h00);
                o.write_back = 1'b0;
                r = a;
            end
            if (it.mode == OP_CPW) begin
                o.flag_n_out = o.flag_n_out ^ o.flag_v_out;
                o.write_back = 1'b0;
                r = a;
            end
            o.result = r;
            return o;
        endfunction

        function void note_accepted(t_alu_in it);
            pending_results.push_back(compute_alu(it));
        endfunction

        function void check_result(t_alu_out got);
            t_alu_out want;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= ReportLimit) begin
                    $display("ERROR: result %h arrived with no item outstanding", got);
                end
                return;
            end
            want = pending_results.pop_front();
            if (got.result !== want.result || got.write_back !== want.write_back ||
                got.flag_n_out !== want.flag_n_out || got.flag_z_out !== want.flag_z_out ||
                got.flag_v_out !== want.flag_v_out || got.flag_c_out !== want.flag_c_out) begin
                mismatch_count++;
                if (mismatch_count <= ReportLimit) begin
                    $display("ERROR: want %h wb %b NZVC %b%b%b%b, got %h wb %b NZVC %b%b%b%b",
                             want.result, want.write_back, want.flag_n_out, want.flag_z_out,
                             want.flag_v_out, want.flag_c_out, got.result, got.write_back,
                             got.flag_n_out, got.flag_z_out, got.flag_v_out, got.flag_c_out);
                end
            end
        endfunction
    endclass

    alu_flag_scoreboard sb = new();

    alu16_with_nzvc_flags_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    // 10 ns clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Results are checked before the item taken at the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                sb.check_result(o_item);
            end
            if (start && !busy) begin
                sb.note_accepted(i_item);
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic t_alu_in make_item(logic [ModeW-1:0] mode, logic [DataW-1:0] a,
                                          logic [DataW-1:0] b, logic [3:0] nzvc);
        t_alu_in it;
        it.mode      = mode;
        it.operand_a = a;
        it.operand_b = b;
        it.flag_n_in = nzvc[3];
        it.flag_z_in = nzvc[2];
        it.flag_v_in = nzvc[1];
        it.flag_c_in = nzvc[0];
        return it;
    endfunction

    // Operands lean towards the sign and carry boundaries.
    function automatic logic [DataW-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return SignMin;
            3: return 16'h7FFF;
            4: return 16'(1 << $urandom_range(0, 15));
            5: return {8'(16'($urandom)), 8'(1 << $urandom_range(0, 7))};
            default: return 16'($urandom);
        endcase
    endfunction

    // Presents one item after a random number of idle cycles. Entered and
    // left at a falling edge.
    task automatic send_item(t_alu_in it, int unsigned idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start  = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Holds off the sender until every outstanding result has come back.
    task automatic wait_drained();
        start = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_random_phase(int unsigned idle_pct);
        for (int unsigned i = 0; i < ItemsPerPhase; i++) begin
            send_item(make_item(4'($urandom_range(0, 15)), pick_operand(), pick_operand(),
                                4'($urandom)), idle_pct);
        end
    endtask

    initial begin
        t_alu_in directed_items[$];
        start   = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Corner cases of every operation, including the unused code.
        directed_items.push_back(make_item(OP_ADD, 16'hFFFF, 16'h0001, 4'b0000));
        directed_items.push_back(make_item(OP_ADD, 16'h7FFF, 16'h0001, 4'b1111));
        directed_items.push_back(make_item(OP_ADD, 16'h8000, 16'h8000, 4'b0101));
        directed_items.push_back(make_item(OP_SUB, 16'h0000, 16'h8000, 4'b0000));
        directed_items.push_back(make_item(OP_SUB, 16'h0000, 16'h0000, 4'b1010));
        directed_items.push_back(make_item(OP_SUB, 16'h8000, 16'h0001, 4'b0000));
        directed_items.push_back(make_item(OP_CPW, 16'h8000, 16'h0001, 4'b0000));
        directed_items.push_back(make_item(OP_CPW, 16'h1234, 16'h1234, 4'b1111));
        directed_items.push_back(make_item(OP_CPB, 16'h1280, 16'hFF80, 4'b1111));
        directed_items.push_back(make_item(OP_CPB, 16'hFF00, 16'h0001, 4'b0000));
        directed_items.push_back(make_item(OP_AND, 16'hFFFF, 16'h0000, 4'b0011));
        directed_items.push_back(make_item(OP_OR, 16'h8000, 16'h7FFF, 4'b0100));
        directed_items.push_back(make_item(OP_XOR, 16'hFFFF, 16'hFFFF, 4'b1011));
        directed_items.push_back(make_item(OP_LDW, 16'h0000, 16'h8000, 4'b0111));
        directed_items.push_back(make_item(OP_LDB, 16'hFFFF, 16'hFF80, 4'b1011));
        directed_items.push_back(make_item(OP_LDB, 16'h1234, 16'hFF00, 4'b1000));
        directed_items.push_back(make_item(OP_NEG, 16'h0000, 16'hFFFF, 4'b0000));
        directed_items.push_back(make_item(OP_NEG, 16'h8000, 16'h0000, 4'b0000));
        directed_items.push_back(make_item(OP_ASL, 16'h4000, 16'h0000, 4'b0001));
        directed_items.push_back(make_item(OP_ASR, 16'h8001, 16'h0000, 4'b0010));
        directed_items.push_back(make_item(OP_NOT, 16'hFFFF, 16'h0000, 4'b0001));
        directed_items.push_back(make_item(OP_ROL, 16'h8000, 16'h0000, 4'b0001));
        directed_items.push_back(make_item(OP_ROR, 16'h0001, 16'h0000, 4'b0001));
        directed_items.push_back(make_item(ModeNop, 16'hA5A5, 16'h5A5A, 4'b1010));
        foreach (directed_items[i]) begin
            send_item(directed_items[i], 0);
        end
        wait_drained();

        // Back-to-back traffic, then heavy and light sender idling.
        run_random_phase(0);
        wait_drained();
        run_random_phase(69);
        wait_drained();
        run_random_phase(21);
        start = 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            if (sb.pending_results.size() != 0) begin
                $display("ERROR: %0d results never arrived", sb.pending_results.size());
            end
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/alu16_pkg.sv
rtl/core/alu16_with_nzvc_flags_top.sv
verif/tb_top.sv
